>>> rtl/wes2d_pkg.sv
// Shared constants, register codes and helpers for the 2D wave equation stencil core.
package wes2d_pkg;

    localparam int DEF_MAX_COLS    = 128;
    localparam int DEF_MAX_ROWS    = 128;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int FRAC_BITS   = 24;
    localparam int COEF_W      = 25;
    localparam int SIZE_W      = 8;
    localparam int CELL_IDX_W  = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 25;
    localparam int SLOT_W      = 2;

    localparam logic [SIZE_W-1:0] RST_GRID_ROWS   = 8'd100;
    localparam logic [SIZE_W-1:0] RST_GRID_COLS   = 8'd100;
    localparam logic [COEF_W-1:0] RST_COEFFICIENT = 25'd7549747;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRID_ROWS   = 2'd0,
        CFG_GRID_COLS   = 2'd1,
        CFG_COEFFICIENT = 2'd2
    } t_cfg_index;

    typedef enum logic [SLOT_W-1:0] {
        SLOT_A = 2'd0,
        SLOT_B = 2'd1,
        SLOT_C = 2'd2
    } t_slot;

    function automatic t_slot slot_prev(input t_slot s);
        t_slot p;
        unique case (s)
            SLOT_A:  p = SLOT_C;
            SLOT_B:  p = SLOT_A;
            SLOT_C:  p = SLOT_B;
            default: p = SLOT_A;
        endcase
        return p;
    endfunction

    function automatic t_slot slot_next(input t_slot s);
        t_slot n;
        unique case (s)
            SLOT_A:  n = SLOT_B;
            SLOT_B:  n = SLOT_C;
            SLOT_C:  n = SLOT_A;
            default: n = SLOT_A;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/wave_equation_stencil_2d_core.sv
// Top level: line-buffered five-point leapfrog wave equation step on a raster cell stream.
// A result passes the read, Laplacian, product and output registers before m_axis_tvalid.
// One item per cycle if not stalled; one write and two row-slot memory reads per item.
// A result for interior cell (r,c) follows acceptance of cell (r+1,c+1).
// Reset (synchronous, active low) clears counters, row slot, pipeline valids and config regs.
// Memory is not cleared; reads for rows 0 and 1 may be stale but emit no result.
module wave_equation_stencil_2d_core
    import wes2d_pkg::*;
#(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    localparam int IN_W       = ((2 * VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W      = ((VALUE_WIDTH + 2 * CELL_IDX_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_W-1:0]        s_axis_tdata,  // prev_value, cur_value
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_W-1:0]       m_axis_tdata,  // new_value, cell_row, cell_col
    output logic                   m_axis_tlast   // last_cell
);

    localparam int VW        = VALUE_WIDTH;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int CW_A      = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int CW        = ((CW_A > SIZE_W) ? CW_A : SIZE_W) + 1;
    localparam int MEM_DEPTH = 3 << COL_W;
    localparam int ADDR_W    = COL_W + SLOT_W;
    localparam int LAP_W     = VW + 3;
    localparam int BASE_W    = VW + 2;
    localparam int PROD_W    = LAP_W + COEF_W + 1;
    localparam int SCL_W     = PROD_W - FRAC_BITS;
    localparam int SUM_W     = SCL_W + 1;
    localparam int PAD_W     = OUT_W - VW - 2 * CELL_IDX_W;

    localparam logic [CW-1:0]     ROWS_HI = CW'(MAX_ROWS);
    localparam logic [CW-1:0]     COLS_HI = CW'(MAX_COLS);
    localparam logic [CW-1:0]     SIZE_LO = CW'(3);
    localparam logic [CW-1:0]     TWO     = CW'(2);
    localparam logic [CW-1:0]     ONE     = CW'(1);
    localparam logic [PROD_W-1:0] ROUND   = PROD_W'(1) << (FRAC_BITS - 1);

    // configuration
    logic [SIZE_W-1:0] r_grid_rows, r_grid_cols;
    logic [COEF_W-1:0] r_coef;

    // raster position
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    t_slot            r_slot, n_slot;

    // row-slot memory {prev, cur} and its registered read ports
    logic [2*VW-1:0] r_mem [MEM_DEPTH];
    logic [2*VW-1:0] r_rd1;
    logic [VW-1:0]   r_rd2;

    // pipeline
    logic                  r_v1, r_v2, r_v3, r_v4;
    logic signed [VW-1:0]  r_s1_cur;
    logic                  r_s1_emit, r_s1_last;
    logic [CELL_IDX_W-1:0] r_s1_row, r_s1_col;
    logic signed [VW-1:0]  r_w1_0, r_w1_1, r_w2_0, r_p1_0, r_below;
    logic signed [LAP_W-1:0]  r_lap;
    logic signed [BASE_W-1:0] r_base2, r_base3;
    logic signed [PROD_W-1:0] r_prod;
    logic [CELL_IDX_W-1:0] r_s2_row, r_s2_col, r_s3_row, r_s3_col, r_o_row, r_o_col;
    logic                  r_s2_last, r_s3_last, r_o_last;
    logic [VW-1:0]         r_o_val;

    logic [CW-1:0]    rows, cols, rows_cfg, cols_cfg, row_c, col_c;
    logic [ROW_W-1:0] row_eff;
    logic [COL_W-1:0] col_eff;
    logic             row_end, w_emit, w_last, s_acc;
    logic             rdy1, rdy2, rdy3, rdy4;
    t_slot            w_slot_up1, w_slot_up2;
    logic [ADDR_W-1:0] w_addr, rd_addr1, rd_addr2;
    logic signed [VW-1:0] in_prev, in_cur, right;
    logic signed [LAP_W-1:0]  w_lap;
    logic signed [BASE_W-1:0] w_base;
    logic [PROD_W-1:0]        w_round;
    logic signed [SCL_W-1:0]  w_scaled;
    logic signed [SUM_W-1:0]  w_sum;
    logic                     w_fits;
    logic [VW-1:0]            w_new;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= RST_GRID_ROWS;
            r_grid_cols <= RST_GRID_COLS;
            r_coef      <= RST_COEFFICIENT;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_GRID_ROWS:   r_grid_rows <= i_cfg_data[SIZE_W-1:0];
                CFG_GRID_COLS:   r_grid_cols <= i_cfg_data[SIZE_W-1:0];
                CFG_COEFFICIENT: r_coef      <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // effective sizes and position
    always_comb begin
        rows_cfg = CW'(r_grid_rows);
        cols_cfg = CW'(r_grid_cols);
        rows = (rows_cfg < SIZE_LO) ? SIZE_LO : ((rows_cfg > ROWS_HI) ? ROWS_HI : rows_cfg);
        cols = (cols_cfg < SIZE_LO) ? SIZE_LO : ((cols_cfg > COLS_HI) ? COLS_HI : cols_cfg);
        row_eff = (CW'(r_row) >= rows) ? '0 : r_row;
        col_eff = (CW'(r_col) >= cols) ? '0 : r_col;
        row_c   = CW'(row_eff);
        col_c   = CW'(col_eff);
        row_end = (col_c == cols - ONE);
        w_emit  = (row_c >= TWO) && (col_c >= TWO);
        w_last  = (row_c == rows - ONE) && row_end;
        n_col   = row_end ? '0 : col_eff + COL_W'(1);
        n_row   = row_end ? ((row_c == rows - ONE) ? '0 : row_eff + ROW_W'(1)) : row_eff;
        n_slot  = row_end ? slot_next(r_slot) : r_slot;
        w_slot_up1 = slot_prev(r_slot);
        w_slot_up2 = slot_prev(w_slot_up1);
        w_addr   = {r_slot, col_eff};
        rd_addr1 = {w_slot_up1, col_eff};
        rd_addr2 = {w_slot_up2, col_eff};
        in_prev  = s_axis_tdata[VW-1:0];
        in_cur   = s_axis_tdata[2*VW-1:VW];
    end

    // handshake
    always_comb begin
        rdy4 = !r_v4 || m_axis_tready;
        rdy3 = !r_v3 || rdy4;
        rdy2 = !r_v2 || rdy3;
        rdy1 = !r_v1 || rdy2;
        s_axis_tready = rdy1;
        s_acc = s_axis_tvalid && rdy1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= SLOT_A;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
        end else begin
            if (s_acc) begin
                r_row  <= n_row;
                r_col  <= n_col;
                r_slot <= n_slot;
            end
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1 && r_s1_emit;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // row-slot memory: write this row, read the two rows above
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_mem[w_addr] <= {in_prev, in_cur};
            r_rd1 <= r_mem[rd_addr1];
            r_rd2 <= r_mem[rd_addr2][VW-1:0];
        end
    end

    // stage 1: neighborhood from window plus fresh reads
    always_comb begin
        right  = r_rd1[VW-1:0];
        w_lap  = LAP_W'(r_w2_0) + LAP_W'(r_below) + LAP_W'(r_w1_1) + LAP_W'(right)
               - (LAP_W'(r_w1_0) <<< 2);
        w_base = (BASE_W'(r_w1_0) <<< 1) - BASE_W'(r_p1_0);
    end

    // stage 4: round, add, saturate
    always_comb begin
        w_round  = r_prod + ROUND;
        w_scaled = w_round[PROD_W-1:FRAC_BITS];
        w_sum    = SUM_W'(r_base3) + SUM_W'(w_scaled);
        w_fits   = (w_sum[SUM_W-1:VW-1] == '0) || (w_sum[SUM_W-1:VW-1] == '1);
        w_new    = w_fits ? w_sum[VW-1:0] : {w_sum[SUM_W-1], {(VW-1){~w_sum[SUM_W-1]}}};
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_cur  <= in_cur;
            r_s1_emit <= w_emit;
            r_s1_last <= w_last;
            r_s1_row  <= CELL_IDX_W'(row_eff - ROW_W'(1));
            r_s1_col  <= CELL_IDX_W'(col_eff - COL_W'(1));
        end
        if (r_v1 && rdy2) begin
            r_w1_0  <= right;
            r_w1_1  <= r_w1_0;
            r_w2_0  <= r_rd2;
            r_p1_0  <= r_rd1[2*VW-1:VW];
            r_below <= r_s1_cur;
        end
        if (rdy2) begin
            r_lap     <= w_lap;
            r_base2   <= w_base;
            r_s2_row  <= r_s1_row;
            r_s2_col  <= r_s1_col;
            r_s2_last <= r_s1_last;
        end
        if (rdy3) begin
            r_prod    <= r_lap * $signed({1'b0, r_coef});
            r_base3   <= r_base2;
            r_s3_row  <= r_s2_row;
            r_s3_col  <= r_s2_col;
            r_s3_last <= r_s2_last;
        end
        if (rdy4) begin
            r_o_val  <= w_new;
            r_o_row  <= r_s3_row;
            r_o_col  <= r_s3_col;
            r_o_last <= r_s3_last;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_o_col, r_o_row, r_o_val};
    assign m_axis_tlast  = r_o_last;

`ifndef ASSERT_OFF
    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v4 |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    a_slots_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |-> (w_slot_up1 != r_slot) && (w_slot_up2 != r_slot)
                  && (w_slot_up1 != w_slot_up2))
        else $error("row slot write collides with a read slot");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot == SLOT_A) || (r_slot == SLOT_B) || (r_slot == SLOT_C))
        else $error("row slot out of range");
`endif

endmodule
